// File: hdl/annular_sector_strip_generator_core_assert.svh
// Assertion macros used by the checker file asc_checker.sv.
`ifndef ANNULAR_SECTOR_STRIP_GENERATOR_CORE_ASSERT_SVH
`define ANNULAR_SECTOR_STRIP_GENERATOR_CORE_ASSERT_SVH

// Same-cycle implication.
`define ASC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("asc assertion failed");

// Next-cycle implication.
`define ASC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("asc assertion failed");

`endif

// File: hdl/asc_pkg.sv
// Package: types, constants and tables of the annular sector strip generator.
`default_nettype none
package asc_pkg;

  localparam int unsigned DEF_MAX_STEPS       = 360;
  localparam int unsigned DEF_COORD_FRAC_BITS = 8;

  localparam int unsigned ANG_W  = 17;
  localparam int unsigned RAD_W  = 16;
  localparam int unsigned STEP_W = 9;
  localparam int unsigned PTS_W  = 10;
  localparam int unsigned XY_W   = 32;
  localparam int unsigned Z_W    = 25;
  localparam int unsigned DVD_W  = 34;
  localparam int unsigned DVS_W  = 17;
  localparam int unsigned CORDIC_N = 16;

  localparam logic [ANG_W-1:0] TURN_Q8    = 17'd92160;
  localparam logic [ANG_W-1:0] QUARTER_Q8 = 17'd23040;
  localparam logic [RAD_W-1:0] RADIUS_ONE = 16'd256;
  localparam logic [21:0]      INV_PI_DEG_Q16 = 22'd3754936;
  localparam logic signed [XY_W-1:0] CORDIC_GAIN_Q30 = 32'sd652032874;
  localparam logic signed [15:0] TRIG_ONE = 16'sd16384;

  typedef enum logic [1:0] {
    CFG_SHRINK = 2'd0,
    CFG_ROOT   = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic                   vld;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } cordic_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic signed [Z_W-1:0] atan_q16(input int unsigned i);
    logic signed [Z_W-1:0] r;
    case (i)
      0:  r = 25'sd2949120;
      1:  r = 25'sd1740967;
      2:  r = 25'sd919879;
      3:  r = 25'sd466945;
      4:  r = 25'sd234379;
      5:  r = 25'sd117304;
      6:  r = 25'sd58666;
      7:  r = 25'sd29335;
      8:  r = 25'sd14668;
      9:  r = 25'sd7334;
      10: r = 25'sd3667;
      11: r = 25'sd1833;
      12: r = 25'sd917;
      13: r = 25'sd458;
      14: r = 25'sd229;
      15: r = 25'sd115;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hdl/annular_sector_strip_generator_core.sv
// Annular sector strip generator: top level.
// Takes one item at a time. A step beat (mode 1) keeps the input busy until
// its point pair is in the output register: the angle is folded into one
// quadrant as the beat is taken, it passes through the chain of CORDIC cells,
// then come trig rounding, the radius products and the output register; a
// pair still waiting on the output holds the following step in its last stage.
// A load beat (mode 0) keeps the input busy through the setup states S_LD1 to
// S_LD3, one pass of the restoring divider for the narrowing angle, then the
// states S_WRAP to S_MEN that set the step count and wrap both angles into one
// turn; full rings and zero outer radius skip the divider. A step with no
// sector loaded yields no result.
`default_nettype none
module annular_sector_strip_generator_core #(
  parameter int unsigned MAX_STEPS       = asc_pkg::DEF_MAX_STEPS,
  parameter int unsigned COORD_FRAC_BITS = asc_pkg::DEF_COORD_FRAC_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                mode_i,
  input  logic [15:0]         vertex_index_i,
  input  logic [16:0]         start_angle_i,
  input  logic [16:0]         end_angle_i,
  input  logic [15:0]         inner_radius_i,
  input  logic [15:0]         outer_radius_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [16:0]  inner_x_o,
  output logic signed [16:0]  inner_y_o,
  output logic signed [16:0]  outer_x_o,
  output logic signed [16:0]  outer_y_o,
  output logic [9:0]          strip_points_o,
  output logic                last_pair_o
);
  import asc_pkg::*;

  localparam int unsigned SHIFT = 22 - COORD_FRAC_BITS;
  localparam logic [STEP_W-1:0] MAX_N = STEP_W'(MAX_STEPS);
  localparam logic signed [34:0] STEP_LIM = 35'(256 * MAX_STEPS);
  // one turn is 45 * 2048; floor(2^28 / 45) for the upper part
  localparam logic [22:0] TURN_RECIP = 23'd5965232;

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_LD1  = 13'b0000000000010,
    S_LD2  = 13'b0000000000100,
    S_LD3  = 13'b0000000001000,
    S_DIV  = 13'b0000000010000,
    S_WRAP = 13'b0000000100000,
    S_QST  = 13'b0000001000000,
    S_MST  = 13'b0000010000000,
    S_QEN  = 13'b0000100000000,
    S_MEN  = 13'b0001000000000,
    S_TRIG = 13'b0010000000000,
    S_MUL  = 13'b0100000000000,
    S_FIN  = 13'b1000000000000
  } state_e;

  function automatic logic signed [16:0] coord_f(input logic signed [32:0] p);
    logic [32:0] m;
    logic [33:0] r;
    m = p[32] ? 33'(-p) : 33'(p);
    r = ({1'b0, m} + (34'(1) << (SHIFT - 1))) >> SHIFT;
    if (r > 34'd65535) begin
      r = 34'd65535;
    end
    return p[32] ? -$signed({1'b0, r[15:0]}) : $signed({1'b0, r[15:0]});
  endfunction

  function automatic logic signed [15:0] trig_f(input logic signed [XY_W-1:0] v);
    logic signed [XY_W-1:0] t;
    logic signed [15:0] r;
    t = v + 32'sd32768;
    r = t[31:16];
    if (r > TRIG_ONE) begin
      r = TRIG_ONE;
    end
    if (r < -TRIG_ONE) begin
      r = -TRIG_ONE;
    end
    return r;
  endfunction

  // quotient estimate of (m >> 11) / 45, low by at most one
  function automatic logic [16:0] wrap_q_f(input logic [DVD_W-1:0] m);
    logic [44:0] prod;
    prod = m[32:11] * TURN_RECIP;
    return prod[44:28];
  endfunction

  function automatic logic [ANG_W-1:0] wrap_r_f(input logic [DVD_W-1:0] m,
                                                input logic [16:0] q, input logic neg);
    logic [21:0] hi;
    logic [7:0] r;
    logic [ANG_W-1:0] rem;
    hi = m[32:11] - 22'(q * 22'd45);
    r = hi[7:0];
    if (r >= 8'd45) begin
      r = r - 8'd45;
    end
    rem = {r[5:0], m[10:0]};
    return (neg && rem != '0) ? TURN_Q8 - rem : rem;
  endfunction

  state_e state_d, state_q;
  logic [8:0]  shrink_d, shrink_q;
  logic [15:0] root_d, root_q;
  logic active_d, active_q;
  logic [ANG_W-1:0] cur_d, cur_q, close_d, close_q;
  logic [RAD_W-1:0] sin_d, sin_q, sout_d, sout_q;
  logic [STEP_W-1:0] left_d, left_q;
  logic [PTS_W-1:0] pts_d, pts_q;

  logic [RAD_W-1:0] r2_d, r2_q, r3_d, r3_q;
  logic [ANG_W-1:0] a0_d, a0_q, a1_d, a1_q;
  logic [8:0] s_d, s_q;
  logic signed [25:0] p_d, p_q;
  logic signed [17:0] span_d, span_q;
  logic [45:0] mag_d, mag_q;
  logic signed [33:0] delta_d, delta_q, en_d, en_q;
  logic st_neg_d, st_neg_q;
  logic [DVD_W-1:0] wmag_d, wmag_q;
  logic [16:0] wq_d, wq_q;
  logic [1:0] quad_d, quad_q;
  logic last_d, last_q;
  logic signed [15:0] tc_d, tc_q, ts_d, ts_q;
  logic signed [32:0] pix_d, pix_q, piy_d, piy_q, pox_d, pox_q, poy_d, poy_q;

  logic out_valid_d, out_valid_q;
  logic signed [16:0] ix_d, ix_q, iy_d, iy_q, ox_d, ox_q, oy_d, oy_q;
  logic [PTS_W-1:0] opts_d, opts_q;
  logic olast_d, olast_q;

  logic div_start;
  logic [DVD_W-1:0] div_dvd;
  logic [DVS_W-1:0] div_dvs;
  div_stat_t div_stat;
  logic [DVD_W-1:0] div_quo;

  cordic_t link [0:CORDIC_N];

  logic accept;
  logic [ANG_W-1:0] ang, fold;
  logic [ANG_W:0] nxt;
  logic signed [26:0] p_full;
  logic [23:0] p_abs;
  logic [46:0] num_sum;
  logic signed [33:0] dr, cap, st_c;
  logic [17:0] span_abs;
  logic signed [34:0] diff;
  logic [STEP_W-1:0] n;
  logic [25:0] h_abs;
  logic signed [16:0] h;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    shrink_d = shrink_q;
    root_d = root_q;
    active_d = active_q;
    cur_d = cur_q;
    close_d = close_q;
    sin_d = sin_q;
    sout_d = sout_q;
    left_d = left_q;
    pts_d = pts_q;
    r2_d = r2_q;
    r3_d = r3_q;
    a0_d = a0_q;
    a1_d = a1_q;
    s_d = s_q;
    p_d = p_q;
    span_d = span_q;
    mag_d = mag_q;
    delta_d = delta_q;
    en_d = en_q;
    st_neg_d = st_neg_q;
    wmag_d = wmag_q;
    wq_d = wq_q;
    quad_d = quad_q;
    last_d = last_q;
    tc_d = tc_q;
    ts_d = ts_q;
    pix_d = pix_q;
    piy_d = piy_q;
    pox_d = pox_q;
    poy_d = poy_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ix_d = ix_q;
    iy_d = iy_q;
    ox_d = ox_q;
    oy_d = oy_q;
    opts_d = opts_q;
    olast_d = olast_q;
    div_start = 1'b0;
    div_dvd = '0;
    div_dvs = {1'b0, r3_q};
    link[0] = '0;

    ang = last_d ? close_q : cur_q;
    fold = '0;
    nxt = '0;
    p_full = '0;
    p_abs = '0;
    num_sum = '0;
    dr = '0;
    cap = '0;
    st_c = '0;
    span_abs = '0;
    diff = '0;
    n = '0;
    h_abs = '0;
    h = '0;

    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SHRINK: shrink_d = cfg_data_i[8:0];
        CFG_ROOT:   root_d = cfg_data_i;
        default:    ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (accept && !mode_i) begin
          if (vertex_index_i == root_q) begin
            a0_d = '0;
            a1_d = '0;
            r2_d = RADIUS_ONE;
            r3_d = RADIUS_ONE;
          end else begin
            a0_d = start_angle_i;
            a1_d = end_angle_i;
            r2_d = inner_radius_i;
            r3_d = outer_radius_i;
          end
          s_d = (shrink_q > 9'd256) ? 9'd256 : shrink_q;
          state_d = S_LD1;
        end else if (accept && mode_i && active_q) begin
          if (left_q != '0) begin
            ang = cur_q;
            nxt = {1'b0, cur_q} + 18'd256;
            cur_d = (nxt >= {1'b0, TURN_Q8}) ? ANG_W'(nxt - {1'b0, TURN_Q8}) : ANG_W'(nxt);
            left_d = left_q - 1'b1;
            last_d = 1'b0;
          end else begin
            ang = close_q;
            active_d = 1'b0;
            last_d = 1'b1;
          end
          if (ang < QUARTER_Q8) begin
            quad_d = 2'd0;
            fold = ang;
          end else if (ang < 17'd46080) begin
            quad_d = 2'd1;
            fold = ang - QUARTER_Q8;
          end else if (ang < 17'd69120) begin
            quad_d = 2'd2;
            fold = ang - 17'd46080;
          end else begin
            quad_d = 2'd3;
            fold = ang - 17'd69120;
          end
          link[0].vld = 1'b1;
          link[0].x = CORDIC_GAIN_Q30;
          link[0].y = '0;
          link[0].z = $signed({fold[15:0], 8'd0, 1'b0}) >>> 1;
          state_d = S_TRIG;
        end
      end
      S_LD1: begin
        p_full = $signed({1'b0, r3_q} - {1'b0, r2_q}) * $signed({1'b0, s_q});
        p_d = 26'(p_full);
        span_d = $signed({1'b0, a1_q}) - $signed({1'b0, a0_q});
        state_d = S_LD2;
      end
      S_LD2: begin
        p_abs = p_q[25] ? 24'(-p_q) : 24'(p_q);
        mag_d = {22'd0, p_abs} * {24'd0, INV_PI_DEG_Q16};
        h_abs = p_q[25] ? 26'(-p_q) : 26'(p_q);
        h = p_q[25] ? -$signed({1'b0, h_abs[24:9]}) : $signed({1'b0, h_abs[24:9]});
        sin_d = RAD_W'($signed({1'b0, r2_q}) + h);
        sout_d = RAD_W'($signed({1'b0, r3_q}) - h);
        state_d = S_LD3;
      end
      S_LD3: begin
        if (span_q == $signed({1'b0, TURN_Q8}) || r3_q == '0) begin
          delta_d = '0;
          state_d = S_WRAP;
        end else begin
          num_sum = {1'b0, mag_q} + (47'(r3_q) << 16);
          div_dvd = DVD_W'(num_sum >> 17);
          div_dvs = {1'b0, r3_q};
          div_start = 1'b1;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          dr = p_q[25] ? -$signed(div_quo) : $signed(div_quo);
          span_abs = span_q[17] ? 18'(-span_q) : 18'(span_q);
          cap = span_q[17] ? -$signed(34'(span_abs >> 3)) : $signed(34'(span_abs >> 3));
          delta_d = (dr < cap) ? dr : cap;
          state_d = S_WRAP;
        end
      end
      S_WRAP: begin
        st_c = $signed({17'd0, a0_q}) + delta_q;
        en_d = $signed({17'd0, a1_q}) - delta_q;
        diff = 35'(en_d) - 35'(st_c);
        if (diff >= STEP_LIM) begin
          n = MAX_N;
        end else if (diff >= 35'sd256) begin
          n = diff[16:8];
        end else begin
          n = STEP_W'(1);
        end
        left_d = n;
        pts_d = {n, 1'b0} + PTS_W'(2);
        st_neg_d = st_c[33];
        wmag_d = st_c[33] ? DVD_W'(-st_c) : DVD_W'(st_c);
        state_d = S_QST;
      end
      S_QST: begin
        wq_d = wrap_q_f(wmag_q);
        state_d = S_MST;
      end
      S_MST: begin
        cur_d = wrap_r_f(wmag_q, wq_q, st_neg_q);
        st_neg_d = en_q[33];
        wmag_d = en_q[33] ? DVD_W'(-en_q) : DVD_W'(en_q);
        state_d = S_QEN;
      end
      S_QEN: begin
        wq_d = wrap_q_f(wmag_q);
        state_d = S_MEN;
      end
      S_MEN: begin
        close_d = wrap_r_f(wmag_q, wq_q, st_neg_q);
        active_d = 1'b1;
        state_d = S_IDLE;
      end
      S_TRIG: begin
        if (link[CORDIC_N].vld) begin
          case (quad_q)
            2'd0: begin
              tc_d = trig_f(link[CORDIC_N].x);
              ts_d = trig_f(link[CORDIC_N].y);
            end
            2'd1: begin
              tc_d = -trig_f(link[CORDIC_N].y);
              ts_d = trig_f(link[CORDIC_N].x);
            end
            2'd2: begin
              tc_d = -trig_f(link[CORDIC_N].x);
              ts_d = -trig_f(link[CORDIC_N].y);
            end
            default: begin
              tc_d = trig_f(link[CORDIC_N].y);
              ts_d = -trig_f(link[CORDIC_N].x);
            end
          endcase
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        pix_d = 33'(tc_q * $signed({1'b0, sin_q}));
        piy_d = 33'(ts_q * $signed({1'b0, sin_q}));
        pox_d = 33'(tc_q * $signed({1'b0, sout_q}));
        poy_d = 33'(ts_q * $signed({1'b0, sout_q}));
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          ix_d = coord_f(pix_q);
          iy_d = coord_f(piy_q);
          ox_d = coord_f(pox_q);
          oy_d = coord_f(poy_q);
          opts_d = pts_q;
          olast_d = last_q;
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  for (genvar g = 0; g < CORDIC_N; g++) begin : g_cell
    asc_cordic_cell #(.IDX(g)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cell_i (link[g]),
      .cell_o (link[g+1])
    );
  end

  asc_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .status_o   (div_stat),
    .quo_o      (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      shrink_q <= '0;
      root_q <= '0;
      active_q <= 1'b0;
      cur_q <= '0;
      close_q <= '0;
      sin_q <= '0;
      sout_q <= '0;
      left_q <= '0;
      pts_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      shrink_q <= shrink_d;
      root_q <= root_d;
      active_q <= active_d;
      cur_q <= cur_d;
      close_q <= close_d;
      sin_q <= sin_d;
      sout_q <= sout_d;
      left_q <= left_d;
      pts_q <= pts_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r2_q <= r2_d;
    r3_q <= r3_d;
    a0_q <= a0_d;
    a1_q <= a1_d;
    s_q <= s_d;
    p_q <= p_d;
    span_q <= span_d;
    mag_q <= mag_d;
    delta_q <= delta_d;
    en_q <= en_d;
    st_neg_q <= st_neg_d;
    wmag_q <= wmag_d;
    wq_q <= wq_d;
    quad_q <= quad_d;
    last_q <= last_d;
    tc_q <= tc_d;
    ts_q <= ts_d;
    pix_q <= pix_d;
    piy_q <= piy_d;
    pox_q <= pox_d;
    poy_q <= poy_d;
    ix_q <= ix_d;
    iy_q <= iy_d;
    ox_q <= ox_d;
    oy_q <= oy_d;
    opts_q <= opts_d;
    olast_q <= olast_d;
  end

  assign out_valid_o    = out_valid_q;
  assign inner_x_o      = ix_q;
  assign inner_y_o      = iy_q;
  assign outer_x_o      = ox_q;
  assign outer_y_o      = oy_q;
  assign strip_points_o = opts_q;
  assign last_pair_o    = olast_q;
endmodule
`default_nettype wire

// File: hdl/asc_cordic_cell.sv
// One CORDIC rotation cell of the sine/cosine chain.
`default_nettype none
module asc_cordic_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  asc_pkg::cordic_t cell_i,
  output asc_pkg::cordic_t cell_o
);
  import asc_pkg::*;

  cordic_t cell_d, cell_q;
  logic signed [XY_W-1:0] dx, dy;
  logic signed [Z_W-1:0]  ang;

  always_comb begin
    dx  = cell_i.y >>> IDX;
    dy  = cell_i.x >>> IDX;
    ang = atan_q16(IDX);
    cell_d.vld = cell_i.vld;
    if (cell_i.z >= 0) begin
      cell_d.x = cell_i.x - dx;
      cell_d.y = cell_i.y + dy;
      cell_d.z = cell_i.z - ang;
    end else begin
      cell_d.x = cell_i.x + dx;
      cell_d.y = cell_i.y - dy;
      cell_d.z = cell_i.z + ang;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;
endmodule
`default_nettype wire

// File: hdl/asc_divider.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module asc_divider (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [asc_pkg::DVD_W-1:0]   dividend_i,
  input  logic [asc_pkg::DVS_W-1:0]   divisor_i,
  output asc_pkg::div_stat_t          status_o,
  output logic [asc_pkg::DVD_W-1:0]   quo_o
);
  import asc_pkg::*;

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic [CNT_W-1:0] cnt_d, cnt_q;
  logic [DVD_W-1:0] dvd_d, dvd_q;
  logic [DVS_W-1:0] rem_d, rem_q, dvs_d, dvs_q;
  logic busy_d, busy_q, done_d, done_q;
  logic [DVS_W:0] trial;
  logic bit_q1;

  always_comb begin
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, dvd_q[DVD_W-1]};
    bit_q1 = (trial >= {1'b0, dvs_q});
    if (start_i) begin
      dvd_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = CNT_W'(DVD_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = bit_q1 ? DVS_W'(trial - {1'b0, dvs_q}) : DVS_W'(trial);
      dvd_d = {dvd_q[DVD_W-2:0], bit_q1};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quo_o = dvd_q;
endmodule
`default_nettype wire

// File: hdl/asc_checker.sv
// Port-level checker for the strip generator, bound to the top level.
`default_nettype none
`include "annular_sector_strip_generator_core_assert.svh"
module asc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               mode_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [16:0] inner_x_o,
  input logic signed [16:0] inner_y_o,
  input logic signed [16:0] outer_x_o,
  input logic signed [16:0] outer_y_o,
  input logic [9:0]         strip_points_o,
  input logic               last_pair_o
);
  `ASC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
    out_valid_o && $stable(inner_x_o) && $stable(outer_y_o) && $stable(last_pair_o))
  `ASC_ASSERT_NOW(a_pts_range, clk_i, rst_ni, out_valid_o,
    strip_points_o >= 10'd4 && strip_points_o <= 10'd722 && !strip_points_o[0])
  `ASC_ASSERT_NOW(a_coord_sat, clk_i, rst_ni, out_valid_o,
    inner_x_o != 17'h10000 && inner_y_o != 17'h10000 &&
    outer_x_o != 17'h10000 && outer_y_o != 17'h10000)
  `ASC_ASSERT_NEXT(a_busy_after_beat, clk_i, rst_ni, in_valid_i && in_ready_o && !mode_i,
    !in_ready_o)
endmodule

bind annular_sector_strip_generator_core asc_checker u_asc_checker (.*);
`default_nettype wire
